// ===== src/assert_macros.svh =====
// Assertion macros for the RTL file that checks itself (the top level).
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, sampled on clk, off while arst_n is low.
`define ASSERT_IMPLIES(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, sampled on clk, off while arst_n is low.
`define ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ===== src/ksbc_pkg.sv =====
// Types, constants and character helpers of the key square bigram cipher.
package ksbc_pkg;

	localparam int unsigned SIDE    = 6;
	localparam int unsigned CELLS   = SIDE * SIDE;
	localparam int unsigned LETTERS = 26;
	localparam int unsigned IDX_W   = 6;
	localparam int unsigned RC_W    = 3;
	// floor(p * 43 / 256) == floor(p / 6) for every p below 36
	localparam int unsigned ROW_RECIP = 43;

	localparam logic [7:0] CH_A   = 8'h41;
	localparam logic [7:0] CH_Z   = 8'h5A;
	localparam logic [7:0] CH_LA  = 8'h61;
	localparam logic [7:0] CH_LZ  = 8'h7A;
	localparam logic [7:0] CH_0   = 8'h30;
	localparam logic [7:0] CH_9   = 8'h39;
	localparam logic [7:0] CASE_D = 8'h20;

	typedef logic [IDX_W-1:0] idx_t;
	typedef logic [RC_W-1:0]  rc_t;

	localparam idx_t SYM_X    = idx_t'(23);
	localparam idx_t LAST_SYM = idx_t'(CELLS - 1);
	localparam idx_t FULL_CNT = idx_t'(CELLS);

	typedef enum logic [1:0] {
		MODE_KEY_CHAR = 2'd0,
		MODE_KEY_DONE = 2'd1,
		MODE_MSG_CHAR = 2'd2,
		MODE_MSG_DONE = 2'd3
	} mode_t;

	typedef enum logic [1:0] {
		OP_NONE,
		OP_FILL,
		OP_PAIR
	} op_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_FILL,
		ST_POS,
		ST_CELL,
		ST_SECOND
	} state_t;

	typedef struct packed {
		logic accept;
		logic fill_step;
		logic addr_load;
		logic emit_first;
		logic emit_second;
	} dp_cmd_t;

	typedef struct packed {
		op_t  op;
		logic fill_last;
		logic out_free;
	} dp_stat_t;

	typedef struct packed {
		logic ok;
		idx_t sym;
	} sym_t;

	// Uppercased alphanumeric symbol: A-Z are 0..25, 0-9 are 26..35.
	function automatic sym_t sym_of(input logic [7:0] c);
		sym_t       r;
		logic [7:0] u;
		u     = c;
		r.ok  = 1'b0;
		r.sym = '0;
		if (c inside {[CH_LA:CH_LZ]}) begin
			u = c - CASE_D;
		end
		if (u inside {[CH_A:CH_Z]}) begin
			r.ok  = 1'b1;
			r.sym = idx_t'(u - CH_A);
		end else if (u inside {[CH_0:CH_9]}) begin
			r.ok  = 1'b1;
			r.sym = idx_t'(u - CH_0) + idx_t'(LETTERS);
		end
		return r;
	endfunction

	function automatic logic [7:0] char_of(input idx_t s);
		logic [7:0] r;
		if (s < idx_t'(LETTERS)) begin
			r = CH_A + 8'(s);
		end else begin
			r = CH_0 + 8'(s - idx_t'(LETTERS));
		end
		return r;
	endfunction

	function automatic rc_t row_of(input idx_t p);
		logic [11:0] m;
		m = 12'(p) * 12'(ROW_RECIP);
		return rc_t'(m >> 8);
	endfunction

	function automatic rc_t col_of(input idx_t p);
		idx_t base;
		base = idx_t'(row_of(p)) * idx_t'(SIDE);
		return rc_t'(p - base);
	endfunction

	function automatic idx_t cell_of(input rc_t row, input rc_t col);
		return idx_t'(row) * idx_t'(SIDE) + idx_t'(col);
	endfunction

endpackage

// ===== src/ksbc_ctrl.sv =====
// Controller state machine: sequences key fill, pair lookup and result output.
module ksbc_ctrl
	import ksbc_pkg::*;
(
	input  logic     clk,
	input  logic     arst_n,
	input  logic     in_valid,
	output logic     in_ready,
	input  dp_stat_t stat,
	output dp_cmd_t  cmd
);

	state_t state_q;
	state_t state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_IDLE: begin
				if (in_valid) begin
					case (stat.op)
						OP_FILL: state_d = ST_FILL;
						OP_PAIR: state_d = ST_POS;
						default: state_d = ST_IDLE;
					endcase
				end
			end
			ST_FILL: begin
				if (stat.fill_last) begin
					state_d = ST_IDLE;
				end
			end
			ST_POS:  state_d = ST_CELL;
			ST_CELL: begin
				if (stat.out_free) begin
					state_d = ST_SECOND;
				end
			end
			ST_SECOND: begin
				if (stat.out_free) begin
					state_d = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	always_comb begin
		in_ready = 1'b0;
		cmd      = '0;
		case (state_q)
			ST_IDLE: begin
				in_ready   = 1'b1;
				cmd.accept = in_valid;
			end
			ST_FILL:   cmd.fill_step   = 1'b1;
			ST_POS:    cmd.addr_load   = 1'b1;
			ST_CELL:   cmd.emit_first  = stat.out_free;
			ST_SECOND: cmd.emit_second = stat.out_free;
			default: begin
				in_ready = 1'b0;
			end
		endcase
	end

endmodule

// ===== src/ksbc_dp.sv =====
// Datapath: key square and symbol position memories, pairing state, output register.
module ksbc_dp
	import ksbc_pkg::*;
(
	input  logic       clk,
	input  logic       arst_n,
	input  dp_cmd_t    cmd,
	output dp_stat_t   stat,
	input  logic [1:0] in_mode,
	input  logic [7:0] in_char,
	output logic       out_valid,
	input  logic       out_ready,
	output logic [7:0] out_char,
	output logic       out_pair_last,
	output logic       out_eom
);

	logic [7:0] square_mem [CELLS];
	idx_t       pos_mem [CELLS];

	logic [CELLS-1:0] present_q;
	idx_t             fill_q;
	idx_t             fill_idx_q;
	logic             ready_q;
	logic             holding_q;
	idx_t             held_q;
	logic             eom_q;
	idx_t             pos1_q;
	idx_t             pos2_q;
	logic [7:0]       cell1_q;
	logic [7:0]       cell2_q;
	logic             out_valid_q;
	logic [7:0]       out_char_q;
	logic             out_pair_last_q;
	logic             out_eom_q;

	mode_t md;
	sym_t  in_sym;
	idx_t  place_sym;
	logic  place_req;
	logic  place_en;
	idx_t  sym2;
	op_t   op;
	rc_t   r1, c1, r2, c2;
	idx_t  addr1, addr2;

	assign md        = mode_t'(in_mode);
	assign in_sym    = sym_of(in_char);
	assign place_sym = cmd.fill_step ? fill_idx_q : in_sym.sym;
	assign place_req = cmd.fill_step
		|| (cmd.accept && md == MODE_KEY_CHAR && in_sym.ok && !ready_q);
	assign place_en  = place_req && !present_q[place_sym] && (fill_q != FULL_CNT);
	assign sym2      = (md == MODE_MSG_DONE) ? SYM_X : in_sym.sym;

	always_comb begin
		case (md)
			MODE_KEY_DONE: op = ready_q ? OP_NONE : OP_FILL;
			MODE_MSG_CHAR: op = (ready_q && in_sym.ok && holding_q) ? OP_PAIR : OP_NONE;
			MODE_MSG_DONE: op = (ready_q && holding_q) ? OP_PAIR : OP_NONE;
			default:       op = OP_NONE;
		endcase
	end

	// output of a pair: square[r1][c2] then square[r2][c1]
	assign r1    = row_of(pos1_q);
	assign c1    = col_of(pos1_q);
	assign r2    = row_of(pos2_q);
	assign c2    = col_of(pos2_q);
	assign addr1 = cell_of(r1, c2);
	assign addr2 = cell_of(r2, c1);

	assign stat.op        = op;
	assign stat.fill_last = (fill_idx_q == LAST_SYM);
	assign stat.out_free  = !out_valid_q || out_ready;

	always_ff @(posedge clk) begin
		if (place_en) begin
			pos_mem[place_sym] <= fill_q;
		end
		if (cmd.accept) begin
			pos1_q <= pos_mem[held_q];
			pos2_q <= pos_mem[sym2];
		end
	end

	always_ff @(posedge clk) begin
		if (place_en) begin
			square_mem[fill_q] <= char_of(place_sym);
		end
		if (cmd.addr_load) begin
			cell1_q <= square_mem[addr1];
			cell2_q <= square_mem[addr2];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			present_q  <= '0;
			fill_q     <= '0;
			fill_idx_q <= '0;
			ready_q    <= 1'b0;
			holding_q  <= 1'b0;
		end else begin
			if (place_en) begin
				present_q[place_sym] <= 1'b1;
				fill_q               <= fill_q + idx_t'(1);
			end
			if (cmd.fill_step) begin
				if (fill_idx_q == LAST_SYM) begin
					fill_idx_q <= '0;
					ready_q    <= 1'b1;
				end else begin
					fill_idx_q <= fill_idx_q + idx_t'(1);
				end
			end
			if (cmd.accept) begin
				if (md == MODE_MSG_CHAR && ready_q && in_sym.ok) begin
					holding_q <= !holding_q;
				end else if (md == MODE_MSG_DONE) begin
					holding_q <= 1'b0;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.accept) begin
			eom_q <= (md == MODE_MSG_DONE);
			if (md == MODE_MSG_CHAR && !holding_q) begin
				held_q <= in_sym.sym;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.emit_first || cmd.emit_second) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.emit_first) begin
			out_char_q      <= cell1_q;
			out_pair_last_q <= 1'b0;
			out_eom_q       <= 1'b0;
		end else if (cmd.emit_second) begin
			out_char_q      <= cell2_q;
			out_pair_last_q <= 1'b1;
			out_eom_q       <= eom_q;
		end
	end

	assign out_valid     = out_valid_q;
	assign out_char      = out_char_q;
	assign out_pair_last = out_pair_last_q;
	assign out_eom       = out_eom_q;

endmodule

// ===== src/key_square_bigram_cipher.sv =====
// Key square bigram cipher, top level: controller plus datapath.
// Key characters, lone message characters and ignored items are taken in ST_IDLE alone.
// A message pair steps through position lookup, cell lookup, then the first and second
// result into the output register, each result waiting while the output stalls.
// Key finished walks all 36 symbols through the single write port.
// arst_n clears the square to empty and the pairing flag; no clearing pass.
`include "assert_macros.svh"

module key_square_bigram_cipher
	import ksbc_pkg::*;
(
	input  logic       clk,
	input  logic       arst_n,
	input  logic       s_tvalid,
	output logic       s_tready,
	input  logic [7:0] s_tdata,  // [7:0] char_in
	input  logic [1:0] s_tuser,  // [1:0] mode
	output logic       m_tvalid,
	input  logic       m_tready,
	output logic [7:0] m_tdata,  // [7:0] out_char
	output logic       m_tuser,  // [0] last_of_pair
	output logic       m_tlast   // end_of_message
);

	dp_cmd_t  cmd;
	dp_stat_t stat;

	ksbc_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (s_tvalid),
		.in_ready (s_tready),
		.stat     (stat),
		.cmd      (cmd)
	);

	ksbc_dp u_dp (
		.clk           (clk),
		.arst_n        (arst_n),
		.cmd           (cmd),
		.stat          (stat),
		.in_mode       (s_tuser),
		.in_char       (s_tdata),
		.out_valid     (m_tvalid),
		.out_ready     (m_tready),
		.out_char      (m_tdata),
		.out_pair_last (m_tuser),
		.out_eom       (m_tlast)
	);

	`ASSERT_IMPLIES(a_eom_on_second, m_tvalid && m_tlast, m_tuser, "end of message on first of pair")
	`ASSERT_NEXT(a_second_follows, m_tvalid && m_tready && !m_tuser, m_tvalid && m_tuser, "second result missing")
	`ASSERT_IMPLIES(a_no_request_in_fill, cmd.fill_step, !s_tready, "request taken during fill")

endmodule

// ===== bench/key_square_bigram_cipher_tb.sv =====
// Testbench for the key square bigram cipher: directed and random requests, scoreboard check.
module key_square_bigram_cipher_tb;
	timeunit 1ns;
	timeprecision 1ps;
	import ksbc_pkg::*;

	localparam logic [7:0] PAD_CHAR     = 8'h58;  // 'X'
	localparam int unsigned RANDOM_ITEMS = 1700;
	localparam int unsigned HOLD_CYCLES  = 300;
	localparam int unsigned DRAIN_CYCLES = 60;
	localparam int unsigned CYCLE_LIMIT  = 1000000;

	typedef struct packed {
		logic [7:0] ch;
		logic       pair_end;
		logic       msg_end;
	} cipher_out_t;

	// Tracks the key square and pairing state; holds the characters still due.
	class bigram_tracker;
		logic [7:0]  square [CELLS];
		int unsigned where [CELLS];   // symbol -> cell
		bit          placed [CELLS];
		int unsigned filled;
		logic [7:0]  held;
		bit          holding;
		bit          ready;
		cipher_out_t due [$];
		int unsigned errors;

		function new();
			foreach (placed[i]) begin
				placed[i] = 1'b0;
				where[i]  = 0;
				square[i] = 8'h00;
			end
			filled  = 0;
			held    = 8'h00;
			holding = 1'b0;
			ready   = 1'b0;
			errors  = 0;
		endfunction

		// A-Z -> 0..25, 0-9 -> 26..35, lowercase folded, -1 otherwise
		function int symbol(logic [7:0] c);
			logic [7:0] u;
			u = c;
			if (c >= CH_LA && c <= CH_LZ) u = c - CASE_D;
			if (u >= CH_A && u <= CH_Z) return int'(u - CH_A);
			if (u >= CH_0 && u <= CH_9) return int'(LETTERS) + int'(u - CH_0);
			return -1;
		endfunction

		function logic [7:0] glyph(int s);
			if (s < int'(LETTERS)) return CH_A + 8'(s);
			return CH_0 + 8'(s - int'(LETTERS));
		endfunction

		function void put(int s);
			if (s < 0 || filled >= CELLS) return;
			if (placed[s]) return;
			square[filled] = glyph(s);
			where[s]       = filled;
			placed[s]      = 1'b1;
			filled++;
		endfunction

		// opposite corners of the rectangle spanned by the two cells
		function void push_pair(int s1, int s2, bit tail);
			int unsigned p1, p2;
			p1 = where[s1];
			p2 = where[s2];
			due.push_back('{square[(p1 / SIDE) * SIDE + p2 % SIDE], 1'b0, 1'b0});
			due.push_back('{square[(p2 / SIDE) * SIDE + p1 % SIDE], 1'b1, tail});
		endfunction

		function void take_request(mode_t m, logic [7:0] c);
			int s;
			case (m)
				MODE_KEY_CHAR: begin
					if (!ready) put(symbol(c));
				end
				MODE_KEY_DONE: begin
					if (!ready) begin
						for (int i = 0; i < int'(CELLS); i++) put(i);
						ready = 1'b1;
					end
				end
				MODE_MSG_CHAR: begin
					s = symbol(c);
					if (ready && s >= 0) begin
						if (!holding) begin
							held    = glyph(s);
							holding = 1'b1;
						end else begin
							holding = 1'b0;
							push_pair(symbol(held), s, 1'b0);
						end
					end
				end
				default: begin
					if (ready && holding) push_pair(symbol(held), symbol(PAD_CHAR), 1'b1);
					holding = 1'b0;
				end
			endcase
		endfunction

		function void check_char(logic [7:0] ch, logic pair_end, logic msg_end);
			cipher_out_t want;
			if (due.size() == 0) begin
				errors++;
				$display("%0t: result with nothing due: char %h last %b end %b",
					$time, ch, pair_end, msg_end);
				return;
			end
			want = due.pop_front();
			if (ch !== want.ch) begin
				errors++;
				$display("%0t: out_char expected %h got %h", $time, want.ch, ch);
			end
			if (pair_end !== want.pair_end) begin
				errors++;
				$display("%0t: last_of_pair expected %b got %b", $time, want.pair_end, pair_end);
			end
			if (msg_end !== want.msg_end) begin
				errors++;
				$display("%0t: end_of_message expected %b got %b", $time, want.msg_end, msg_end);
			end
		endfunction
	endclass

	logic       clk;
	logic       arst_n   = 1'b0;
	logic       s_tvalid = 1'b0;
	logic       s_tready;
	logic [7:0] s_tdata  = 8'h00;
	logic [1:0] s_tuser  = MODE_KEY_CHAR;
	logic       m_tvalid;
	logic       m_tready = 1'b0;
	logic [7:0] m_tdata;
	logic       m_tuser;
	logic       m_tlast;

	bigram_tracker tracker;
	int unsigned   idle_pct  = 0;
	int unsigned   stall_pct = 0;
	bit            hold_req  = 1'b0;
	int unsigned   hold_left = 0;
	int unsigned   cycles    = 0;

	key_square_bigram_cipher dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tuser  (m_tuser),
		.m_tlast  (m_tlast)
	);

	initial begin
		clk = 1'b0;
		forever #6 clk = ~clk;
	end

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles == CYCLE_LIMIT) begin
			$display("== FAIL ==");
			$finish;
		end
	end

	// receiver: checks accepted results, stalls at random, and holds off on request
	always @(posedge clk) begin
		if (m_tvalid && m_tready) tracker.check_char(m_tdata, m_tuser, m_tlast);
		if (hold_req) begin
			hold_req  = 1'b0;
			hold_left = HOLD_CYCLES;
		end
		if (!arst_n) begin
			m_tready <= 1'b0;
		end else if (hold_left > 0) begin
			m_tready <= 1'b0;
			hold_left--;
		end else begin
			m_tready <= ($urandom_range(99) >= stall_pct);
		end
	end

	task automatic send_req(input mode_t m, input logic [7:0] c);
		s_tvalid <= 1'b1;
		s_tuser  <= m;
		s_tdata  <= c;
		do @(posedge clk); while (!s_tready);
		tracker.take_request(m, c);
		while ($urandom_range(99) < idle_pct) begin
			s_tvalid <= 1'b0;
			@(posedge clk);
		end
	endtask

	// mostly alphanumeric in either case, sometimes any byte
	function automatic logic [7:0] pick_char();
		int unsigned k;
		k = $urandom_range(99);
		if (k < 15) return 8'($urandom_range(255));
		if (k < 25) return CH_0 + 8'($urandom_range(9));
		if (k < 60) return CH_LA + 8'($urandom_range(25));
		return CH_A + 8'($urandom_range(25));
	endfunction

	initial begin
		int unsigned counted;
		int unsigned msg_len;
		int unsigned k;
		logic [7:0]  c;

		tracker = new();
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// before the square is ready: message requests are dropped
		send_req(MODE_MSG_CHAR, 8'h61);
		send_req(MODE_MSG_DONE, 8'h00);
		send_req(MODE_KEY_CHAR, 8'h6B);  // 'k'
		send_req(MODE_KEY_CHAR, 8'h45);  // 'E'
		send_req(MODE_KEY_CHAR, 8'h2D);  // '-', ignored
		send_req(MODE_KEY_CHAR, 8'h00);
		send_req(MODE_KEY_CHAR, 8'hFF);
		send_req(MODE_KEY_CHAR, 8'h39);  // '9'
		send_req(MODE_KEY_CHAR, 8'h4B);  // 'K', repeat of 'k'
		send_req(MODE_KEY_CHAR, 8'h7A);  // 'z'
		send_req(MODE_KEY_CHAR, 8'h30);  // '0'
		repeat ($urandom_range(30)) send_req(MODE_KEY_CHAR, pick_char());
		send_req(MODE_KEY_DONE, 8'($urandom_range(255)));

		// square frozen from here on
		send_req(MODE_KEY_CHAR, 8'h51);
		send_req(MODE_KEY_DONE, 8'hFF);
		send_req(MODE_MSG_DONE, 8'hFF);               // nothing held
		send_req(MODE_MSG_CHAR, tracker.square[0]);   // same row: the two swap
		send_req(MODE_MSG_CHAR, tracker.square[1]);
		send_req(MODE_MSG_CHAR, tracker.square[35]);  // same cell twice
		send_req(MODE_MSG_CHAR, tracker.square[35]);
		send_req(MODE_MSG_CHAR, tracker.square[0]);   // opposite corners
		send_req(MODE_MSG_CHAR, tracker.square[35]);
		send_req(MODE_MSG_CHAR, 8'h6D);               // 'm'
		send_req(MODE_MSG_CHAR, 8'h21);               // dropped between pair chars
		send_req(MODE_MSG_CHAR, 8'hFF);
		send_req(MODE_MSG_CHAR, 8'h5A);               // 'Z'
		send_req(MODE_MSG_CHAR, 8'h37);               // lone '7', padded
		send_req(MODE_MSG_DONE, 8'h00);
		send_req(MODE_MSG_CHAR, 8'h78);               // lone 'x', padded with X
		send_req(MODE_MSG_DONE, 8'h00);
		send_req(MODE_MSG_DONE, 8'h00);
		send_req(MODE_MSG_CHAR, 8'h00);

		// long receiver hold while requests keep coming
		hold_req = 1'b1;
		counted  = 0;
		while (counted < RANDOM_ITEMS) begin
			case (counted * 4 / RANDOM_ITEMS)
				0: begin idle_pct = 0;  stall_pct = 0;  end
				1: begin idle_pct = 59; stall_pct = 0;  end
				2: begin idle_pct = 0;  stall_pct = 59; end
				default: begin idle_pct = 32; stall_pct = 32; end
			endcase
			k = $urandom_range(99);
			if (k < 8) begin
				// ignored noise
				if (k < 4) send_req(MODE_KEY_CHAR, pick_char());
				else send_req(MODE_KEY_DONE, 8'($urandom_range(255)));
				counted++;
			end else begin
				msg_len = $urandom_range(1, 12);
				repeat (msg_len) begin
					c = pick_char();
					send_req(MODE_MSG_CHAR, c);
					counted++;
				end
				// some messages run on without an end marker
				if ($urandom_range(99) < 85) begin
					send_req(MODE_MSG_DONE, 8'($urandom_range(255)));
					counted++;
				end
			end
		end
		s_tvalid <= 1'b0;

		while (tracker.due.size() != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (tracker.errors == 0 && tracker.due.size() == 0) begin
			$display("== PASS ==");
		end else begin
			$display("== FAIL ==");
		end
		$finish;
	end

endmodule

// ===== key_square_bigram_cipher.f =====
+incdir+src
src/ksbc_pkg.sv
src/ksbc_ctrl.sv
src/ksbc_dp.sv
src/key_square_bigram_cipher.sv
bench/key_square_bigram_cipher_tb.sv
